// ----- hw/rtl/rswd_pkg.sv -----
// shared types, codes and constants of the root stack with swap delete
package rswd_pkg;

   // default sizing of the stack
   localparam int CAPACITY_DEF     = 1024;
   localparam int PAGE_ENTRIES_DEF = 64;

   // fixed field widths
   localparam int ADDR_W    = 64;
   localparam int MARGIN_W  = 11;
   localparam int STATUS_W  = 3;
   localparam int TOTAL_W   = 11;
   localparam int PAGES_W   = 5;
   localparam int EVENT_W   = 2;
   localparam int CSR_IDX_W = 1;

   // request modes
   localparam logic MODE_PUSH   = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SWAPPED   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd4;

   // page event codes
   localparam logic [EVENT_W-1:0] EVENT_NONE     = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_MAPPED   = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_RELEASED = 2'd2;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_MARGIN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_MARGIN = 1'b1;
   localparam logic [MARGIN_W-1:0]  GROW_RESET        = 11'd19;
   localparam logic [MARGIN_W-1:0]  SHRINK_RESET      = 11'd192;

   // request beat
   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] root_address;
   } req_type;

   // result beat
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  entry_total;
      logic [PAGES_W-1:0]  pages_in_use;
      logic [EVENT_W-1:0]  page_event;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic                load;
      logic                idx_top;
      logic                idx_dec;
      logic                top_capture;
      logic                swap_write;
      logic                commit;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_delete;
      logic full;
      logic empty;
      logic rd_match;
      logic idx_zero;
      logic out_free;
   } sts_type;

endpackage

// ----- hw/rtl/root_stack_with_swap_delete.sv -----
// top level of the root stack with swap delete
//
// Request channel req_*: one beat is a push (mode 0) or a delete (mode 1)
// of a 64 bit root address. Result channel rsp_*: exactly one beat per
// request with status, entry total, mapped pages and page event.
// Margins are set through csr_write / csr_index / csr_data; the user must
// write them only while idle, as the block itself does not enforce it. A push
// passes through accept, decide and commit. A delete passes through accept,
// decide, top compare and commit when the address sits on top, plus one scan
// step for each entry below the top that the downward scan reads. The scan reads
// one entry per cycle from the single read port of the root ram.
// One item is worked on at a time; a new beat is accepted once the previous
// one has moved into the result register, so a result may wait there while
// the next item runs. When the receiver stalls with a result waiting, the
// following item holds in its commit step until the result is taken.
// Reset (synchronous) empties the stack, sets one mapped page and the
// margin registers to 19 and 192; ram contents are left as they are.
module root_stack_with_swap_delete
   import rswd_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int PAGE_ENTRIES = PAGE_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MARGIN_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(CAPACITY);

   cmd_type           cmd;
   sts_type           sts;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ADDR_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ADDR_W-1:0] ram_rd_data;

   // sequencer
   rswd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // bookkeeping and result register
   rswd_dp #(
      .CAPACITY     (CAPACITY),
      .PAGE_ENTRIES (PAGE_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // root address storage
   rswd_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- hw/rtl/rswd_ram.sv -----
// generic single write, single read ram with registered read data
module rswd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rswd_ctrl.sv -----
// controller state machine: sequences push, top compare and downward scan
module rswd_ctrl
   import rswd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_TOP    = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;

   logic [2:0]          state_ff;
   logic [2:0]          state_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.is_delete) begin
               status_in = sts.full ? STATUS_FULL : STATUS_OK;
               state_in  = ST_FIN;
            end else if (sts.empty) begin
               status_in = STATUS_UNDERFLOW;
               state_in  = ST_FIN;
            end else begin
               cmd.idx_top = 1'b1;
               state_in    = ST_TOP;
            end
         end
         ST_TOP: begin
            cmd.top_capture = 1'b1;
            if (sts.rd_match) begin
               status_in = STATUS_OK;
               state_in  = ST_FIN;
            end else if (sts.idx_zero) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_FIN;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.rd_match) begin
               cmd.swap_write = 1'b1;
               status_in      = STATUS_SWAPPED;
               state_in       = ST_FIN;
            end else if (sts.idx_zero) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_FIN;
            end else begin
               cmd.idx_dec = 1'b1;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.status = status_ff;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

`ifndef ASSERT_OFF
   // a finished item waits while the result slot is occupied
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !sts.out_free) |=> (state_ff == ST_FIN))
      else $error("finish left without a free result slot");

   // a swap write only comes from a matching scan
   a_swap_from_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.swap_write |-> (state_ff == ST_SCAN && sts.rd_match))
      else $error("swap write outside a matching scan");

   // every accepted beat is followed by the decision step
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECIDE))
      else $error("accepted beat not decided");
`endif

endmodule

// ----- hw/rtl/rswd_dp.sv -----
// datapath: count and page bookkeeping, scan index, margins and result register
module rswd_dp
   import rswd_pkg::*;
#(
   parameter int CAPACITY     = CAPACITY_DEF,
   parameter int PAGE_ENTRIES = PAGE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  req_type                     req_data,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [MARGIN_W-1:0]         csr_data,
   input  cmd_type                     cmd,
   output sts_type                     sts,
   output logic                        ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
   output logic [ADDR_W-1:0]           ram_wr_data,
   output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
   input  logic [ADDR_W-1:0]           ram_rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rsp_type                     rsp_data
);

   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int MAX_PAGES = (CAPACITY / PAGE_ENTRIES < 1) ? 1 : CAPACITY / PAGE_ENTRIES;
   localparam int PG_W      = $clog2(MAX_PAGES + 1);
   localparam int CMP_W     = $clog2(CAPACITY + PAGE_ENTRIES + 2048) + 1;

   logic [CNT_W-1:0]    count_ff,    count_in;
   logic [PG_W-1:0]     pages_ff,    pages_in;
   logic [MARGIN_W-1:0] grow_ff,     grow_in;
   logic [MARGIN_W-1:0] shrink_ff,   shrink_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                mode_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [ADDR_W-1:0]   top_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;

   logic [CNT_W-1:0]    count_dec;
   logic [CMP_W-1:0]    mapped;
   logic                grow_hit;
   logic                shrink_hit;
   logic                do_push;
   logic                do_pop;
   logic [EVENT_W-1:0]  event_code;
   logic                out_free;

   // page arithmetic
   assign count_dec  = count_ff - 1'b1;
   assign mapped     = CMP_W'(pages_ff) * CMP_W'(PAGE_ENTRIES);
   assign grow_hit   = ((CMP_W'(count_ff) + CMP_W'(grow_ff)) > mapped)
                       && (pages_ff < PG_W'(MAX_PAGES));
   assign shrink_hit = ((CMP_W'(count_dec) + CMP_W'(shrink_ff)) < mapped)
                       && (pages_ff > PG_W'(1));
   assign do_push    = (mode_ff == MODE_PUSH) && (cmd.status == STATUS_OK);
   assign do_pop     = (mode_ff == MODE_DELETE) && (cmd.status != STATUS_UNDERFLOW);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // status toward the controller
   always_comb begin
      sts.is_delete = (mode_ff == MODE_DELETE);
      sts.full      = (count_ff == CNT_W'(CAPACITY));
      sts.empty     = (count_ff == '0);
      sts.rd_match  = (ram_rd_data == addr_ff);
      sts.idx_zero  = (scan_idx_ff == '0);
      sts.out_free  = out_free;
   end

   // scan index; the ram reads its next value, so read data lines up with scan_idx_ff
   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.idx_top) begin
         scan_idx_in = count_dec[IDX_W-1:0];
      end else if (cmd.idx_dec) begin
         scan_idx_in = scan_idx_ff - 1'b1;
      end
   end

   assign ram_rd_addr = scan_idx_in;

   // ram write: push on commit, or overwrite a match with the top entry
   assign ram_wr_en   = (cmd.commit && do_push) || cmd.swap_write;
   assign ram_wr_addr = cmd.swap_write ? scan_idx_ff : count_ff[IDX_W-1:0];
   assign ram_wr_data = cmd.swap_write ? top_data_ff : addr_ff;

   // commit of count and pages
   always_comb begin
      count_in   = count_ff;
      pages_in   = pages_ff;
      event_code = EVENT_NONE;
      if (do_push) begin
         count_in = count_ff + 1'b1;
         if (grow_hit) begin
            pages_in   = pages_ff + 1'b1;
            event_code = EVENT_MAPPED;
         end
      end else if (do_pop) begin
         count_in = count_dec;
         if (shrink_hit) begin
            pages_in   = pages_ff - 1'b1;
            event_code = EVENT_RELEASED;
         end
      end
   end

   // result beat
   always_comb begin
      rsp_data_in.status       = cmd.status;
      rsp_data_in.entry_total  = TOTAL_W'(count_in);
      rsp_data_in.pages_in_use = PAGES_W'(pages_in);
      rsp_data_in.page_event   = event_code;
      rsp_valid_in             = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // margin registers
   always_comb begin
      grow_in   = grow_ff;
      shrink_in = shrink_ff;
      if (csr_write && csr_index == CSR_GROW_MARGIN) begin
         grow_in = csr_data;
      end
      if (csr_write && csr_index == CSR_SHRINK_MARGIN) begin
         shrink_in = csr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pages_ff     <= PG_W'(1);
         grow_ff      <= GROW_RESET;
         shrink_ff    <= SHRINK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         grow_ff      <= grow_in;
         shrink_ff    <= shrink_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            count_ff <= count_in;
            pages_ff <= pages_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (cmd.load) begin
         mode_ff <= req_data.mode;
         addr_ff <= req_data.root_address;
      end
      if (cmd.top_capture) begin
         top_data_ff <= ram_rd_data;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // stack count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stack count beyond capacity");

   // mapped pages stay between one and the ceiling
   a_pages_bound: assert property (@(posedge clock) disable iff (reset)
      (pages_ff >= PG_W'(1)) && (pages_ff <= PG_W'(MAX_PAGES)))
      else $error("mapped pages out of bounds");

   // a commit never overwrites a result still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit into an occupied result slot");

   // a popping delete lowers the count by exactly one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_pop) |=> (count_ff == $past(count_dec)))
      else $error("delete did not pop one entry");
`endif

endmodule
